/* hdl/hanf_pkg.sv */
// ----------------------------------------------------------------------------
// hanf_pkg
// Shared types and constants for the HEVC Annex B normalizer and flagger.
// ----------------------------------------------------------------------------
package hanf_pkg;

    localparam int LEN_W     = 25;
    localparam int CMD_BYTES = 8;
    localparam int CNT_W     = 4;

    localparam logic [LEN_W-1:0] MAX_FRAME_BYTES = 25'd16777216;
    localparam logic [31:0]      START_CODE      = 32'h0000_0001;
    localparam logic [7:0]       SC_ZERO         = 8'h00;
    localparam logic [7:0]       SC_ONE          = 8'h01;

    localparam logic [5:0] NAL_BLA_LO = 6'd19;
    localparam logic [5:0] NAL_IRAP_HI = 6'd21;
    localparam logic [5:0] NAL_VPS    = 6'd32;
    localparam logic [5:0] NAL_PPS    = 6'd34;
    localparam logic [5:0] NAL_VCL_HI = 6'd31;

    localparam logic [1:0] FLAG_NONE  = 2'd0;
    localparam logic [1:0] FLAG_SYNC  = 2'd1;
    localparam logic [1:0] FLAG_CODEC = 2'd2;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_PASS,
        PH_LENGTH,
        PH_PAYLOAD,
        PH_DROP
    } phase_t;

    // bytes to emit for one accepted input, data[0] goes out first
    typedef struct packed {
        logic [CMD_BYTES-1:0][7:0] data;
        logic [CNT_W-1:0]          count;
        logic                      last;
        logic                      key;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

/* hdl/hanf_front.sv */
// ----------------------------------------------------------------------------
// hanf_front
// Parses the input byte stream, picks the frame mode and builds emit requests.
// ----------------------------------------------------------------------------
module hanf_front
    import hanf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             annexb_mode,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [7:0]       in_byte,
    input  logic [LEN_W-1:0] frame_length,
    input  logic             is_key,
    input  q_status_t        q_status,
    output logic             push,
    output cmd_t             cmd
);

    phase_t           phase_reg, phase_next;
    logic [31:0]      head_reg, head_next;
    logic [LEN_W-1:0] pos_reg, pos_next;
    logic [31:0]      lshift_reg, lshift_next;
    logic [1:0]       lcount_reg, lcount_next;
    logic [LEN_W-1:0] unit_reg, unit_next;
    logic             key_reg, key_next;

    logic             accept;
    logic [LEN_W-1:0] eff_len;
    logic [LEN_W-1:0] done;
    logic [LEN_W-1:0] remaining;
    logic             last;
    logic             key_now;
    logic [31:0]      head_new;
    logic [31:0]      lshift_new;
    logic [2:0]       n;
    logic [2:0]       sh;
    logic [3:0][7:0]  held;
    logic             sc3;
    logic             sc4;
    logic [LEN_W-1:0] unit_dec;

    assign in_ready = !q_status.full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        if (frame_length == '0)
            eff_len = LEN_W'(1);
        else if (frame_length > MAX_FRAME_BYTES)
            eff_len = MAX_FRAME_BYTES;
        else
            eff_len = frame_length;

        done      = pos_reg + LEN_W'(1);
        last      = done >= eff_len;
        remaining = last ? '0 : eff_len - done;
        key_now   = (pos_reg == '0) ? is_key : key_reg;
        head_new  = {head_reg[23:0], in_byte};
        lshift_new = {lshift_reg[23:0], in_byte};
        n         = (done < LEN_W'(4)) ? done[2:0] : 3'd4;

        for (int k = 0; k < 4; k++)
        begin
            sh = n - 3'd1 - 3'(k);
            held[k] = (3'(k) < n) ? 8'(head_new >> {sh[1:0], 3'b000}) : 8'h00;
        end

        sc4 = (n == 3'd4) && (head_new == START_CODE);
        sc3 = ((n == 3'd3) && (head_new[23:0] == START_CODE[23:0])) ||
              ((n == 3'd4) && (head_new[31:8] == START_CODE[23:0]));
        unit_dec = (unit_reg != '0) ? unit_reg - LEN_W'(1) : unit_reg;

        phase_next  = phase_reg;
        head_next   = head_reg;
        lshift_next = lshift_reg;
        lcount_next = lcount_reg;
        unit_next   = unit_reg;
        key_next    = key_now;
        pos_next    = done;
        cmd.data    = '0;
        cmd.count   = '0;
        cmd.last    = last;
        cmd.key     = key_now;

        case (phase_reg)
            PH_HEADER:
            begin
                head_next = head_new;
                if (done >= LEN_W'(4) || last)
                begin
                    if (!annexb_mode || sc4 || sc3)
                    begin
                        for (int k = 0; k < 4; k++)
                            cmd.data[k] = held[k];
                        cmd.count  = CNT_W'(n);
                        phase_next = PH_PASS;
                    end
                    else if (n == 3'd4 && eff_len > LEN_W'(4) && head_new != '0 &&
                             head_new <= 32'(eff_len - LEN_W'(4)))
                    begin
                        cmd.data[0] = SC_ZERO;
                        cmd.data[1] = SC_ZERO;
                        cmd.data[2] = SC_ZERO;
                        cmd.data[3] = SC_ONE;
                        cmd.count   = CNT_W'(4);
                        unit_next   = head_new[LEN_W-1:0];
                        phase_next  = PH_PAYLOAD;
                    end
                    else
                    begin
                        cmd.data[0] = SC_ZERO;
                        cmd.data[1] = SC_ZERO;
                        cmd.data[2] = SC_ZERO;
                        cmd.data[3] = SC_ONE;
                        for (int k = 0; k < 4; k++)
                            cmd.data[k+4] = held[k];
                        cmd.count  = CNT_W'(4) + CNT_W'(n);
                        phase_next = PH_PASS;
                    end
                end
            end
            PH_PASS:
            begin
                cmd.data[0] = in_byte;
                cmd.count   = CNT_W'(1);
            end
            PH_PAYLOAD:
            begin
                cmd.data[0] = in_byte;
                cmd.count   = CNT_W'(1);
                unit_next   = unit_dec;
                if (unit_dec == '0)
                begin
                    phase_next  = PH_LENGTH;
                    lshift_next = '0;
                    lcount_next = '0;
                end
            end
            PH_LENGTH:
            begin
                lshift_next = lshift_new;
                if (lcount_reg == 2'd3)
                begin
                    lcount_next = '0;
                    if (lshift_new == '0 || lshift_new > 32'(remaining))
                        phase_next = PH_DROP;
                    else
                    begin
                        cmd.data[0] = SC_ZERO;
                        cmd.data[1] = SC_ZERO;
                        cmd.data[2] = SC_ZERO;
                        cmd.data[3] = SC_ONE;
                        cmd.count   = CNT_W'(4);
                        unit_next   = lshift_new[LEN_W-1:0];
                        phase_next  = PH_PAYLOAD;
                    end
                end
                else
                    lcount_next = lcount_reg + 2'd1;
            end
            default:
            begin
            end
        endcase

        if (last)
        begin
            phase_next  = PH_HEADER;
            head_next   = '0;
            pos_next    = '0;
            lshift_next = '0;
            lcount_next = '0;
            unit_next   = '0;
            key_next    = 1'b0;
        end
    end

    assign push = accept && (cmd.count != '0 || last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEADER;
            head_reg   <= '0;
            pos_reg    <= '0;
            lshift_reg <= '0;
            lcount_reg <= '0;
            unit_reg   <= '0;
            key_reg    <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            head_reg   <= head_next;
            pos_reg    <= pos_next;
            lshift_reg <= lshift_next;
            lcount_reg <= lcount_next;
            unit_reg   <= unit_next;
            key_reg    <= key_next;
        end
    end

endmodule

/* hdl/hanf_queue.sv */
// ----------------------------------------------------------------------------
// hanf_queue
// Small request queue between the parser and the output serializer.
// ----------------------------------------------------------------------------
module hanf_queue
    import hanf_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  cmd_t      wr_data,
    input  logic      pop,
    output cmd_t      rd_data,
    output q_status_t status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int QCNT_W = $clog2(DEPTH + 1);

    cmd_t              mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (push && !pop)
            count_next = count_reg + QCNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign rd_data      = mem[rd_ptr_reg];
    assign status.full  = count_reg == QCNT_W'(DEPTH);
    assign status.empty = count_reg == '0;

endmodule

/* hdl/hanf_back.sv */
// ----------------------------------------------------------------------------
// hanf_back
// Serializes queued requests one byte per cycle unless stalled by an empty
// queue or out_ready, scans NAL headers and sets frame flags on the last item.
// ----------------------------------------------------------------------------
module hanf_back
    import hanf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      annexb_mode,
    input  cmd_t      head,
    input  q_status_t q_status,
    output logic      pop,
    output logic      out_valid,
    input  logic      out_ready,
    output logic [7:0] out_byte,
    output logic      byte_valid,
    output logic      frame_last,
    output logic [1:0] frame_flags
);

    logic             valid_reg, valid_next;
    logic [7:0]       byte_reg, byte_next;
    logic             bvalid_reg, bvalid_next;
    logic             last_reg, last_next;
    logic [1:0]       flags_reg, flags_next;
    logic [2:0]       idx_reg, idx_next;
    logic [5:0][7:0]  win_reg, win_next;
    logic [2:0]       fill_reg, fill_next;
    logic             irap_reg, irap_next;
    logic             ps_reg, ps_next;
    logic             slice_reg, slice_next;

    logic             fire;
    logic             bare;
    logic [7:0]       b;
    logic             cmd_end;
    logic             item_last;
    logic [5:0][7:0]  win_new;
    logic [2:0]       fill_new;
    logic             hit;
    logic [7:0]       nal;
    logic [5:0]       nal_type;
    logic             irap_new;
    logic             ps_new;
    logic             slice_new;
    logic [1:0]       flags;

    always_comb
    begin
        fire      = (!valid_reg || out_ready) && !q_status.empty;
        bare      = head.count == '0;
        b         = head.data[idx_reg];
        cmd_end   = bare || ({1'b0, idx_reg} == head.count - CNT_W'(1));
        item_last = head.last && cmd_end;

        win_new  = {b, win_reg[5:1]};
        fill_new = (fill_reg < 3'd6) ? fill_reg + 3'd1 : fill_reg;
        hit = 1'b0;
        nal = 8'h00;
        if (fill_new == 3'd6)
        begin
            if (win_new[0] == 8'h00 && win_new[1] == 8'h00 && win_new[2] == 8'h01)
            begin
                hit = 1'b1;
                nal = win_new[3];
            end
            else if (win_new[0] == 8'h00 && win_new[1] == 8'h00 &&
                     win_new[2] == 8'h00 && win_new[3] == 8'h01)
            begin
                hit = 1'b1;
                nal = win_new[4];
            end
        end
        nal_type  = nal[6:1];
        irap_new  = irap_reg;
        ps_new    = ps_reg;
        slice_new = slice_reg;
        if (hit && !bare)
        begin
            if (nal_type inside {[NAL_BLA_LO:NAL_IRAP_HI]})
                irap_new = 1'b1;
            else if (nal_type inside {[NAL_VPS:NAL_PPS]})
                ps_new = 1'b1;
            else if (nal_type <= NAL_VCL_HI)
                slice_new = 1'b1;
        end

        if (head.key)
            flags = FLAG_SYNC;
        else if (annexb_mode)
            flags = irap_new ? FLAG_SYNC : ((ps_new && !slice_new) ? FLAG_CODEC : FLAG_NONE);
        else
            flags = FLAG_NONE;

        valid_next  = valid_reg;
        byte_next   = byte_reg;
        bvalid_next = bvalid_reg;
        last_next   = last_reg;
        flags_next  = flags_reg;
        idx_next    = idx_reg;
        win_next    = win_reg;
        fill_next   = fill_reg;
        irap_next   = irap_reg;
        ps_next     = ps_reg;
        slice_next  = slice_reg;

        if (fire)
        begin
            valid_next  = 1'b1;
            byte_next   = bare ? 8'h00 : b;
            bvalid_next = !bare;
            last_next   = item_last;
            flags_next  = item_last ? flags : FLAG_NONE;
            idx_next    = cmd_end ? '0 : idx_reg + 3'd1;
            if (item_last)
            begin
                win_next   = '0;
                fill_next  = '0;
                irap_next  = 1'b0;
                ps_next    = 1'b0;
                slice_next = 1'b0;
            end
            else if (!bare)
            begin
                win_next   = win_new;
                fill_next  = fill_new;
                irap_next  = irap_new;
                ps_next    = ps_new;
                slice_next = slice_new;
            end
        end
        else if (out_ready)
            valid_next = 1'b0;
    end

    assign pop = fire && cmd_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
            win_reg   <= '0;
            fill_reg  <= '0;
            irap_reg  <= 1'b0;
            ps_reg    <= 1'b0;
            slice_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
            win_reg   <= win_next;
            fill_reg  <= fill_next;
            irap_reg  <= irap_next;
            ps_reg    <= ps_next;
            slice_reg <= slice_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg   <= byte_next;
        bvalid_reg <= bvalid_next;
        last_reg   <= last_next;
        flags_reg  <= flags_next;
    end

    assign out_valid   = valid_reg;
    assign out_byte    = byte_reg;
    assign byte_valid  = bvalid_reg;
    assign frame_last  = last_reg;
    assign frame_flags = flags_reg;

endmodule

/* hdl/hevc_annexb_normalizer_flagger_top.sv */
// ----------------------------------------------------------------------------
// hevc_annexb_normalizer_flagger_top
// Path: the parser writes each accepted request into the QUEUE_DEPTH-entry
//   request queue, which absorbs them; the serializer loads m_* from its head.
// Throughput: one output byte per cycle from the serializer while m_tready
//   is high; one input byte per cycle while each yields at most one byte and
//   the queue has room. A mode decision emits up to 8 bytes in one request.
// Reset: rst_n is asynchronous; control state clears, annexb_mode goes to 1.
// ----------------------------------------------------------------------------
module hevc_annexb_normalizer_flagger_top
    import hanf_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // in_byte[7:0], frame_length[32:8], zero pad
    input  logic [0:0]  s_tuser,   // is_key[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // out_byte[7:0]
    output logic        m_tlast,   // frame_last
    output logic [2:0]  m_tuser    // byte_valid[0], frame_flags[2:1]
);

    logic      annexb_mode_reg;
    logic      q_push;
    logic      q_pop;
    cmd_t      q_wr;
    cmd_t      q_rd;
    q_status_t q_status;
    logic      byte_valid;
    logic [1:0] frame_flags;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            annexb_mode_reg <= 1'b1;
        else if (cfg_wr_en)
            annexb_mode_reg <= cfg_wr_data;
    end

    hanf_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .annexb_mode  (annexb_mode_reg),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_byte      (s_tdata[7:0]),
        .frame_length (s_tdata[32:8]),
        .is_key       (s_tuser[0]),
        .q_status     (q_status),
        .push         (q_push),
        .cmd          (q_wr)
    );

    hanf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_data (q_wr),
        .pop     (q_pop),
        .rd_data (q_rd),
        .status  (q_status)
    );

    hanf_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .annexb_mode (annexb_mode_reg),
        .head        (q_rd),
        .q_status    (q_status),
        .pop         (q_pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_byte    (m_tdata),
        .byte_valid  (byte_valid),
        .frame_last  (m_tlast),
        .frame_flags (frame_flags)
    );

    assign m_tuser = {frame_flags, byte_valid};

`ifndef SYNTH
    a_bare_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tlast)
        else $error("bare end marker without frame end");

    a_flags_only_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> m_tuser[2:1] == FLAG_NONE)
        else $error("frame flags set before frame end");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_status.empty && !(q_push && q_status.full))
        else $error("request queue underflow or overflow");
`endif

endmodule

/* sim/hevc_annexb_normalizer_flagger_top_test.sv */
// ----------------------------------------------------------------------------
// hevc_annexb_normalizer_flagger_top_test
// Self-checking bench for the HEVC Annex B normalizer and NAL-type flagger.
// Frames are queued as byte requests and driven with random gaps. Each
// accepted request runs through a local model of the parser and the output
// scan window. Output bytes are compared in order with the model's results.
// The receiver stalls at random and sometimes holds off for a long stretch so
// that the block backs up. annexb_mode is changed between phases while idle.
// ----------------------------------------------------------------------------
module hevc_annexb_normalizer_flagger_top_test;
    import hanf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int HOLD_CYCLES = 250;

    typedef struct packed {
        logic [7:0]       data;
        logic [LEN_W-1:0] len;
        logic             key;
    } byte_req_t;

    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic       last;
        logic [1:0] flags;
    } out_item_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_wr_data = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic [2:0]  m_tuser;

    byte_req_t   pending_in[$];
    out_item_t   expected_out[$];
    out_item_t   step_out[$];
    logic [7:0]  frame_buf[$];

    // model state
    logic             annexb_on;
    phase_t           fr_phase;
    logic [31:0]      head_word;
    logic [LEN_W-1:0] byte_pos;
    logic [31:0]      len_word;
    logic [1:0]       len_bytes;
    logic [31:0]      unit_left;
    logic [7:0]       scan_win[0:5];
    int               scan_fill;
    logic             saw_irap;
    logic             saw_param_set;
    logic             saw_slice;
    logic             key_seen;

    int          error_count = 0;
    int          frames_sent = 0;
    int          lp_frames = 0;
    int          sc_frames = 0;
    int          bytes_sent = 0;
    int          results_checked = 0;
    int          cfg_writes = 0;
    int          holds_done = 0;
    int          hold_left = 0;
    int          next_hold_at = 120;
    int          send_gap = 0;
    int          send_calm = 0;
    int          recv_stall = 0;
    int          recv_calm = 0;
    int          cycle_count = 0;
    byte_req_t   req;
    out_item_t   want;

    hevc_annexb_normalizer_flagger_top DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        if (error_count < 40)
            $display("%0t ns: mismatch: %s", $time, what);
        error_count++;
    endtask

    // ---------------- model ----------------

    function automatic void clear_frame();
        fr_phase      = PH_HEADER;
        head_word     = '0;
        byte_pos      = '0;
        len_word      = '0;
        len_bytes     = '0;
        unit_left     = '0;
        for (int i = 0; i < 6; i++)
            scan_win[i] = 8'h00;
        scan_fill     = 0;
        saw_irap      = 1'b0;
        saw_param_set = 1'b0;
        saw_slice     = 1'b0;
        key_seen      = 1'b0;
    endfunction

    function automatic void classify_nal(input logic [7:0] hdr);
        logic [5:0] t;
        t = hdr[6:1];
        if (t >= NAL_BLA_LO && t <= NAL_IRAP_HI)
            saw_irap = 1'b1;
        else if (t >= NAL_VPS && t <= NAL_PPS)
            saw_param_set = 1'b1;
        else if (t <= NAL_VCL_HI)
            saw_slice = 1'b1;
    endfunction

    function automatic void push_byte(input logic [7:0] b);
        int i;
        step_out.insert(step_out.size(), out_item_t'{b, 1'b1, 1'b0, FLAG_NONE});
        for (i = 0; i < 5; i++)
            scan_win[i] = scan_win[i+1];
        scan_win[5] = b;
        if (scan_fill < 6)
            scan_fill++;
        if (scan_fill == 6)
        begin
            if (scan_win[0] == SC_ZERO && scan_win[1] == SC_ZERO && scan_win[2] == SC_ONE)
                classify_nal(scan_win[3]);
            else if (scan_win[0] == SC_ZERO && scan_win[1] == SC_ZERO &&
                     scan_win[2] == SC_ZERO && scan_win[3] == SC_ONE)
                classify_nal(scan_win[4]);
        end
    endfunction

    function automatic void push_start_code();
        int k;
        for (k = 3; k >= 0; k--)
            push_byte(START_CODE[8*k +: 8]);
    endfunction

    function automatic void push_held(input int n);
        int k;
        logic [31:0] w;
        for (k = 0; k < n; k++)
        begin
            w = head_word >> (8 * (n - 1 - k));
            push_byte(w[7:0]);
        end
    endfunction

    function automatic void choose_mode(input int n, input logic [31:0] eff_len);
        logic sc4;
        logic sc3;
        logic [31:0] w;
        w   = head_word >> (8 * (n >= 3 ? n - 3 : 0));
        sc4 = (n >= 4) && (head_word == START_CODE);
        sc3 = (n >= 3) && (w[23:0] == START_CODE[23:0]);
        if (!annexb_on || sc4 || sc3)
        begin
            push_held(n);
            fr_phase = PH_PASS;
        end
        else if (n == 4 && eff_len > 32'd4 && head_word != 32'd0 &&
                 head_word <= eff_len - 32'd4)
        begin
            push_start_code();
            unit_left = head_word;
            fr_phase  = PH_PAYLOAD;
        end
        else
        begin
            push_start_code();
            push_held(n);
            fr_phase = PH_PASS;
        end
    endfunction

    task automatic normalize_byte(input logic [7:0] b, input logic [LEN_W-1:0] len_field,
                                  input logic key);
        logic [31:0] eff_len;
        logic [31:0] done;
        logic [31:0] remaining;
        logic        last;
        logic [1:0]  flags;
        eff_len = {7'd0, len_field};
        if (eff_len == 32'd0)
            eff_len = 32'd1;
        if (eff_len > {7'd0, MAX_FRAME_BYTES})
            eff_len = {7'd0, MAX_FRAME_BYTES};
        step_out.delete();
        if (byte_pos == '0)
            key_seen = key;
        done      = {7'd0, byte_pos} + 32'd1;
        last      = (done >= eff_len);
        remaining = last ? 32'd0 : eff_len - done;
        case (fr_phase)
            PH_HEADER:
            begin
                head_word = {head_word[23:0], b};
                if (done >= 32'd4 || last)
                    choose_mode(done < 32'd4 ? int'(done) : 4, eff_len);
            end
            PH_PASS:
                push_byte(b);
            PH_PAYLOAD:
            begin
                push_byte(b);
                if (unit_left != 32'd0)
                    unit_left--;
                if (unit_left == 32'd0)
                begin
                    fr_phase  = PH_LENGTH;
                    len_word  = '0;
                    len_bytes = '0;
                end
            end
            PH_LENGTH:
            begin
                len_word = {len_word[23:0], b};
                if (len_bytes == 2'd3)
                begin
                    len_bytes = '0;
                    if (len_word == 32'd0 || len_word > remaining)
                        fr_phase = PH_DROP;
                    else
                    begin
                        push_start_code();
                        unit_left = len_word;
                        fr_phase  = PH_PAYLOAD;
                    end
                end
                else
                    len_bytes++;
            end
            default:
                ;
        endcase
        byte_pos = done[LEN_W-1:0];
        if (last)
        begin
            if (key_seen)
                flags = FLAG_SYNC;
            else if (annexb_on)
                flags = saw_irap ? FLAG_SYNC :
                        ((saw_param_set && !saw_slice) ? FLAG_CODEC : FLAG_NONE);
            else
                flags = FLAG_NONE;
            if (step_out.size() == 0)
                step_out.insert(0, out_item_t'{8'h00, 1'b0, 1'b0, FLAG_NONE});
            step_out[step_out.size()-1].last  = 1'b1;
            step_out[step_out.size()-1].flags = flags;
            clear_frame();
        end
        foreach (step_out[i])
            expected_out.insert(expected_out.size(), step_out[i]);
    endtask

    // ---------------- stimulus helpers ----------------

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] nal_header();
        int r;
        logic [5:0] t;
        r = $urandom_range(0, 9);
        if (r <= 2)
            t = 6'($urandom_range(19, 21));
        else if (r <= 5)
            t = 6'($urandom_range(32, 34));
        else if (r <= 7)
            t = 6'($urandom_range(0, 31));
        else
            t = 6'($urandom_range(35, 63));
        return {1'($urandom_range(0, 1)), t, 1'($urandom_range(0, 1))};
    endfunction

    function automatic void append_byte(input logic [7:0] b);
        frame_buf.insert(frame_buf.size(), b);
    endfunction

    function automatic void put_be32(input logic [31:0] w);
        int k;
        for (k = 3; k >= 0; k--)
            append_byte(w[8*k +: 8]);
    endfunction

    function automatic void add_item(input logic [7:0] b, input logic [LEN_W-1:0] len,
                                     input logic key);
        pending_in.insert(pending_in.size(), byte_req_t'{b, len, key});
        bytes_sent++;
    endfunction

    // odd_len: lengths of at least the frame size mid-frame, zero or at most the frame size on the last byte
    function automatic void add_frame(input logic key, input logic odd_len);
        int n;
        int i;
        logic [LEN_W-1:0] len_val;
        n = frame_buf.size();
        for (i = 0; i < n; i++)
        begin
            if (!odd_len)
                len_val = LEN_W'(n);
            else if (i < n - 1)
                len_val = LEN_W'($urandom_range(33554431, n));
            else if ($urandom_range(0, 3) == 0)
                len_val = '0;
            else
                len_val = LEN_W'($urandom_range(n, 1));
            add_item(frame_buf[i], len_val, i == 0 ? key : 1'($urandom_range(0, 1)));
        end
        frames_sent++;
    endfunction

    function automatic void queue_random_frame();
        int kind;
        int units;
        int ulen;
        int extra;
        int u;
        int j;
        logic [31:0] word;
        frame_buf.delete();
        kind = $urandom_range(0, 9);
        if (kind <= 4)
        begin
            units = $urandom_range(1, 3);
            for (u = 0; u < units; u++)
            begin
                ulen = $urandom_range(1, 8);
                put_be32(32'(ulen));
                append_byte(nal_header());
                for (j = 1; j < ulen; j++)
                    append_byte(rand_byte());
            end
            extra = $urandom_range(0, 4);
            case ($urandom_range(0, 9))
                0:
                    repeat ($urandom_range(1, 3))
                        append_byte(rand_byte());
                1:
                begin
                    put_be32(32'd0);
                    repeat (extra)
                        append_byte(rand_byte());
                end
                2:
                begin
                    put_be32($urandom_range(0, 1) ? $urandom
                                                  : 32'(extra + $urandom_range(1, 300)));
                    repeat (extra)
                        append_byte(rand_byte());
                end
                3:
                begin
                    word = $urandom_range(0, 1) ? 32'd0 : $urandom;
                    for (j = 0; j < 4; j++)
                        frame_buf[j] = word[8*(3-j) +: 8];
                end
                default:
                    ;
            endcase
            lp_frames++;
        end
        else if (kind <= 6)
        begin
            units = $urandom_range(1, 3);
            for (u = 0; u < units; u++)
            begin
                if ($urandom_range(0, 1))
                    put_be32(START_CODE);
                else
                begin
                    append_byte(SC_ZERO);
                    append_byte(SC_ZERO);
                    append_byte(SC_ONE);
                end
                append_byte(nal_header());
                repeat ($urandom_range(0, 6))
                    append_byte(rand_byte());
            end
            sc_frames++;
        end
        else if (kind <= 8)
        begin
            repeat ($urandom_range(1, 12))
                append_byte($urandom_range(0, 3) == 0 ? SC_ZERO : rand_byte());
        end
        else
        begin
            repeat ($urandom_range(1, 4))
            begin
                case ($urandom_range(0, 2))
                    0:       append_byte(SC_ZERO);
                    1:       append_byte(SC_ONE);
                    default: append_byte(rand_byte());
                endcase
            end
        end
        add_frame(1'($urandom_range(0, 3) == 0), 1'($urandom_range(0, 4) == 0));
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 50);
    endfunction

    // ---------------- driver ----------------

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                normalize_byte(s_tdata[7:0], s_tdata[32:8], s_tuser[0]);
            if (!s_tvalid || s_tready)
            begin
                if (send_gap > 0 || pending_in.size() == 0)
                begin
                    s_tvalid <= 1'b0;
                    if (send_gap > 0)
                        send_gap--;
                end
                else
                begin
                    req = pending_in[0];
                    pending_in.delete(0);
                    s_tvalid <= 1'b1;
                    s_tdata  <= {7'd0, req.len, req.data};
                    s_tuser  <= req.key;
                    if (send_calm > 0)
                    begin
                        send_calm--;
                        send_gap = 0;
                    end
                    else
                    begin
                        send_gap = pick_gap();
                        if ($urandom_range(0, 29) == 0)
                            send_calm = $urandom_range(20, 60);
                    end
                end
            end
        end
    end

    // ---------------- receiver ----------------

    // long hold-off so the request side backs up
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
        else if (results_checked >= next_hold_at)
        begin
            hold_left    <= HOLD_CYCLES;
            next_hold_at = next_hold_at + 500;
            holds_done++;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_left > 0)
            m_tready <= 1'b0;
        else if (recv_stall > 0)
        begin
            recv_stall--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
            if (recv_calm > 0)
                recv_calm--;
            else
            begin
                recv_stall = pick_gap();
                if ($urandom_range(0, 24) == 0)
                    recv_calm = $urandom_range(20, 60);
            end
        end
    end

    // ---------------- monitor ----------------

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_out.size() == 0)
                report_mismatch($sformatf("unexpected byte %02h last %b", m_tdata, m_tlast));
            else
            begin
                want = expected_out[0];
                expected_out.delete(0);
                if (m_tdata !== want.data)
                    report_mismatch($sformatf("out_byte %02h, want %02h", m_tdata, want.data));
                if (m_tuser[0] !== want.valid)
                    report_mismatch($sformatf("byte_valid %b, want %b", m_tuser[0], want.valid));
                if (m_tlast !== want.last)
                    report_mismatch($sformatf("frame_last %b, want %b", m_tlast, want.last));
                if (m_tuser[2:1] !== want.flags)
                    report_mismatch($sformatf("frame_flags %0d, want %0d",
                                              m_tuser[2:1], want.flags));
            end
            results_checked <= results_checked + 1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // ---------------- sequence ----------------

    task automatic wait_drained();
        @(negedge clk);
        while (pending_in.size() != 0 || s_tvalid || expected_out.size() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
    endtask

    task automatic set_annexb_mode(input logic v);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        annexb_on = v;
        cfg_writes++;
    endtask

    initial
    begin
        int phase_idx;
        int target;
        annexb_on = 1'b1;
        clear_frame();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        set_annexb_mode(1'b1);
        @(negedge clk);
        add_item(8'hFF, 25'd1, 1'b1);             // single byte, key
        add_item(8'h00, 25'd0, 1'b0);             // zero length taken as one
        frame_buf = '{8'h00, 8'h00, 8'h01};       // three-byte start code
        add_frame(1'b0, 1'b0);
        frame_buf = '{8'h00, 8'h00, 8'h00, 8'h01};
        add_frame(1'b0, 1'b0);
        frame_buf = '{8'h00, 8'h00, 8'h00, 8'h02, 8'h40, 8'h01, 8'h7F};
        add_frame(1'b0, 1'b0);                    // VPS unit, tail byte dropped
        frame_buf = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h26};
        add_frame(1'b0, 1'b0);                    // zero first length: fallback
        add_item(8'h12, MAX_FRAME_BYTES, 1'b0);   // lengths at and above the cap
        add_item(8'h34, 25'h1FF_FFFF, 1'b1);
        add_item(8'h56, 25'd3, 1'b0);
        frames_sent++;
        wait_drained();

        for (phase_idx = 0; phase_idx < 3; phase_idx++)
        begin
            set_annexb_mode(phase_idx == 1 ? 1'b0 : 1'b1);
            @(negedge clk);
            target = bytes_sent + (phase_idx == 0 ? 160 : 85);
            while (bytes_sent < target)
                queue_random_frame();
            wait_drained();
        end

        repeat (20) @(negedge clk);
        if (expected_out.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_out.size()));

        $display("%0d frames (%0d length-prefixed, %0d start-coded), %0d bytes in, %0d out",
                 frames_sent, lp_frames, sc_frames, bytes_sent, results_checked);
        $display("annexb_mode written %0d times, %0d long output holds",
                 cfg_writes, holds_done);
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

/* filelist.f */
hdl/hanf_pkg.sv
hdl/hanf_front.sv
hdl/hanf_queue.sv
hdl/hanf_back.sv
hdl/hevc_annexb_normalizer_flagger_top.sv
sim/hevc_annexb_normalizer_flagger_top_test.sv
